[hdl/sts_pkg.sv]
// Shared types, constants and helper functions for the s-expression token scanner.
// No dependencies; every other file of the scanner imports this package.
package sts_pkg;

  // Scan mode of the front end.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SYMBOL = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_STRING = 2'd3
  } scan_mode_t;

  // Token kind codes as they appear on the result channel.
  localparam logic [2:0] KIND_OPEN   = 3'd0;
  localparam logic [2:0] KIND_CLOSE  = 3'd1;
  localparam logic [2:0] KIND_SYMBOL = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_NUMBER = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  // Characters with a fixed role in the grammar.
  localparam logic [7:0] CHAR_OPEN    = 8'h28;
  localparam logic [7:0] CHAR_CLOSE   = 8'h29;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam logic [15:0] MAX16      = 16'hFFFF;
  localparam logic [31:0] MAX32      = 32'hFFFF_FFFF;
  localparam logic [3:0]  MAX_FRAC   = 4'd15;
  localparam logic [1:0]  DOTS_LIMIT = 2'd2;

  // One input request.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] start_row;
    logic [15:0] start_col;
    logic [15:0] token_length;
    logic        negative_sign;
    logic [31:0] mantissa;
    logic [3:0]  fraction_digits;
    logic        last_of_run;
  } out_item_t;

  // All results caused by one input byte: one or two of them.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } res_group_t;

  // Saturating 16-bit increment.
  function automatic logic [15:0] inc16(input logic [15:0] x);
    inc16 = (x == MAX16) ? MAX16 : x + 16'd1;
  endfunction

  // Build a result with the run marker cleared.
  function automatic out_item_t make_item(input logic [2:0] kind, input logic [15:0] row,
                                          input logic [15:0] col, input logic [15:0] len,
                                          input logic neg, input logic [31:0] mant,
                                          input logic [3:0] frac);
    out_item_t item;
    item.token_kind      = kind;
    item.start_row       = row;
    item.start_col       = col;
    item.token_length    = len;
    item.negative_sign   = neg;
    item.mantissa        = mant;
    item.fraction_digits = frac;
    item.last_of_run     = 1'b0;
    make_item = item;
  endfunction

endpackage

[hdl/sts_front.sv]
// Front end of the token scanner: classifies each byte, keeps the scan state
// and builds the group of results the byte causes. Depends on sts_pkg.
module sts_front
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       push_valid,
  input  logic       push_ready,
  output res_group_t push_data
);

  scan_mode_t  mode_r, mode_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] trow_r, trow_nxt;
  logic [15:0] tcol_r, tcol_nxt;
  logic [15:0] body_r, body_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  frac_r, frac_nxt;
  logic [1:0]  dots_r, dots_nxt;
  logic        minus_r, minus_nxt;

  logic [7:0]  c;
  logic        last;
  logic        is_digit, is_alpha, is_alnum, is_space;
  logic [3:0]  digit_val;
  logic [35:0] acc_times_ten;
  logic        a_v, b_v, c_v;
  out_item_t   a_item, b_item, c_item;
  logic        accept;

  assign c        = in_data.text_byte;
  assign last     = in_data.end_of_text;
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Byte classes.
  assign is_digit  = (c >= "0") && (c <= "9");
  assign is_alpha  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_alnum  = is_digit || is_alpha;
  assign is_space  = (c == CHAR_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  assign digit_val = c[3:0];

  // Ten times the accumulator plus the digit, wide enough to detect overflow.
  assign acc_times_ten = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, digit_val};

  // Next scan state and the results of this byte, in the order they leave.
  always_comb begin
    mode_nxt  = mode_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    trow_nxt  = trow_r;
    tcol_nxt  = tcol_r;
    body_nxt  = body_r;
    acc_nxt   = acc_r;
    frac_nxt  = frac_r;
    dots_nxt  = dots_r;
    minus_nxt = minus_r;
    a_v       = 1'b0;
    b_v       = 1'b0;
    c_v       = 1'b0;
    a_item    = make_item(KIND_STRING, trow_r, tcol_r, body_r, 1'b0, 32'd0, 4'd0);
    b_item    = make_item(KIND_ERROR, row_r, col_r, 16'd1, 1'b0, 32'd0, 4'd0);
    c_item    = make_item(KIND_ERROR, trow_r, tcol_r, body_r, 1'b0, 32'd0, 4'd0);

    if (mode_r == MODE_STRING) begin
      if (c == CHAR_QUOTE) begin
        a_v      = 1'b1;
        mode_nxt = MODE_IDLE;
      end else begin
        body_nxt = inc16(body_r);
      end
    end else if (mode_r == MODE_SYMBOL && is_alnum) begin
      body_nxt = inc16(body_r);
    end else if (mode_r == MODE_NUMBER && (is_digit || c == CHAR_DOT)) begin
      // Digits after the second dot only lengthen the token.
      body_nxt = inc16(body_r);
      if (c == CHAR_DOT) begin
        if (dots_r < DOTS_LIMIT) begin
          dots_nxt = dots_r + 2'd1;
        end
      end else if (dots_r < DOTS_LIMIT) begin
        acc_nxt = (acc_times_ten[35:32] != 4'd0) ? MAX32 : acc_times_ten[31:0];
        if (dots_r == 2'd1 && frac_r != MAX_FRAC) begin
          frac_nxt = frac_r + 4'd1;
        end
      end
    end else begin
      // The byte ends any open word and is then scanned from idle.
      if (mode_r == MODE_SYMBOL) begin
        a_v    = 1'b1;
        a_item = make_item(KIND_SYMBOL, trow_r, tcol_r, body_r, 1'b0, 32'd0, 4'd0);
      end else if (mode_r == MODE_NUMBER) begin
        a_v    = 1'b1;
        a_item = make_item(KIND_NUMBER, trow_r, tcol_r, body_r, minus_r, acc_r, frac_r);
      end
      mode_nxt = MODE_IDLE;

      if (!is_space) begin
        if (c == CHAR_OPEN) begin
          b_v    = 1'b1;
          b_item = make_item(KIND_OPEN, row_r, col_r, 16'd1, 1'b0, 32'd0, 4'd0);
        end else if (c == CHAR_CLOSE) begin
          b_v    = 1'b1;
          b_item = make_item(KIND_CLOSE, row_r, col_r, 16'd1, 1'b0, 32'd0, 4'd0);
        end else if (c == CHAR_MINUS || is_alnum || c == CHAR_QUOTE) begin
          // Start a new token at the current position.
          trow_nxt  = row_r;
          tcol_nxt  = col_r;
          body_nxt  = 16'd0;
          acc_nxt   = 32'd0;
          frac_nxt  = 4'd0;
          dots_nxt  = 2'd0;
          minus_nxt = 1'b0;
          if (c == CHAR_MINUS) begin
            mode_nxt  = MODE_NUMBER;
            minus_nxt = 1'b1;
          end else if (is_digit) begin
            mode_nxt = MODE_NUMBER;
            acc_nxt  = {28'd0, digit_val};
            body_nxt = 16'd1;
          end else if (is_alpha) begin
            mode_nxt = MODE_SYMBOL;
            body_nxt = 16'd1;
          end else begin
            mode_nxt = MODE_STRING;
          end
        end else begin
          b_v = 1'b1;
        end
      end
    end

    // The final byte flushes whatever token is still open.
    if (last) begin
      if (mode_nxt == MODE_STRING) begin
        c_v    = 1'b1;
        c_item = make_item(KIND_ERROR, trow_nxt, tcol_nxt, body_nxt, 1'b0, 32'd0, 4'd0);
      end else if (mode_nxt == MODE_SYMBOL) begin
        c_v    = 1'b1;
        c_item = make_item(KIND_SYMBOL, trow_nxt, tcol_nxt, body_nxt, 1'b0, 32'd0, 4'd0);
      end else if (mode_nxt == MODE_NUMBER) begin
        c_v    = 1'b1;
        c_item = make_item(KIND_NUMBER, trow_nxt, tcol_nxt, body_nxt, minus_nxt, acc_nxt,
                           frac_nxt);
      end
      mode_nxt = MODE_IDLE;
      row_nxt  = 16'd0;
      col_nxt  = 16'd0;
    end else if (c == CHAR_NEWLINE) begin
      row_nxt = inc16(row_r);
      col_nxt = 16'd0;
    end else begin
      col_nxt = inc16(col_r);
    end
  end

  // Pack the up to two results and mark the final one of the run.
  always_comb begin
    push_data.first  = a_v ? a_item : (b_v ? b_item : c_item);
    push_data.second = (a_v && b_v) ? b_item : c_item;
    push_data.two    = (a_v && b_v) || (a_v && c_v) || (b_v && c_v);
    push_data.first.last_of_run  = !push_data.two;
    push_data.second.last_of_run = 1'b1;
    push_valid = in_valid && (a_v || b_v || c_v);
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      trow_r  <= '0;
      tcol_r  <= '0;
      body_r  <= '0;
      acc_r   <= '0;
      frac_r  <= '0;
      dots_r  <= '0;
      minus_r <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      trow_r  <= trow_nxt;
      tcol_r  <= tcol_nxt;
      body_r  <= body_nxt;
      acc_r   <= acc_nxt;
      frac_r  <= frac_nxt;
      dots_r  <= dots_nxt;
      minus_r <= minus_nxt;
    end
  end

endmodule

[hdl/sts_queue.sv]
// Short queue of result groups between the scanner front end and the output
// side. Depends on sts_pkg for the group type.
module sts_queue
  import sts_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  res_group_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output res_group_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  res_group_t          entries [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != FullCnt);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Fill level follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

endmodule

[hdl/sts_back.sv]
// Output side of the token scanner: holds one result group in a register and
// delivers its results one request at a time. Depends on sts_pkg.
module sts_back
  import sts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  res_group_t pop_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  res_group_t grp_r;
  logic       valid_r, valid_nxt;
  logic       idx_r, idx_nxt;
  logic       sent, done;

  assign out_valid = valid_r;
  assign out_data  = idx_r ? grp_r.second : grp_r.first;
  assign sent      = valid_r && out_ready;
  assign done      = sent && (idx_r || !grp_r.two);
  assign pop_ready = !valid_r || done;

  // Step through the held group, reloading from the queue when it is used up.
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (pop_ready) begin
      valid_nxt = pop_valid;
      idx_nxt   = 1'b0;
    end else if (sent) begin
      idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Group payload needs no reset.
  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      grp_r <= pop_data;
    end
  end

endmodule

[hdl/sexpr_token_scanner.sv]
// Top level of the s-expression token scanner.
// Depends on sts_pkg, sts_front, sts_queue and sts_back.
//
// The scanner takes one text byte per cycle and reports open and close parens,
// symbols, strings, numbers and errors with their start row and column, body
// length and, for numbers, sign, decimal mantissa and fraction digit count.
// A byte is accepted every cycle as long as the result queue (QUEUE_DEPTH
// groups) has room; a byte causes zero, one or two results, and the output
// side delivers one result per cycle while out_ready is high, so a byte that
// ends a word on a paren or a bad byte, or a final byte that ends one word and
// opens another, takes two output transfers. Results are registered in the
// queue and then in the output side; last_of_run marks the final result of a byte.
module sexpr_token_scanner
  import sts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       push_valid, push_ready;
  res_group_t push_data;
  logic       pop_valid, pop_ready;
  res_group_t pop_data;

  // Byte classification and scan state.
  sts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Result groups waiting for the output side.
  sts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // One result per request on the output channel.
  sts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hdl/sts_checker.sv]
// Port-level checks for the s-expression token scanner, bound to its top level.
// Depends on sts_pkg and sexpr_token_scanner.
module sts_checker
  import sts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A waiting input request stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input request dropped or changed while waiting");

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Parens always have a body of one byte.
  a_paren_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == KIND_OPEN || out_data.token_kind == KIND_CLOSE)
    |-> out_data.token_length == 16'd1)
    else $error("paren with wrong length");

  // Only numbers carry sign, mantissa and fraction digits.
  a_num_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind != KIND_NUMBER
    |-> !out_data.negative_sign && out_data.mantissa == 32'd0
        && out_data.fraction_digits == 4'd0)
    else $error("number fields set on a non-number result");

endmodule

bind sexpr_token_scanner sts_checker u_sts_checker (.*);
